// File: src/pce_pkg.sv
// shared types and constants of the parametric crc engine
// no dependencies; compiled first
package pce_pkg;

  localparam int MAX_CRC_BITS = 64;
  localparam int CRC_W        = 64;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_INDEX_W  = 3;

  localparam logic [1:0]            RST_WIDTH_SELECT = 2'd2;
  localparam logic [CFG_DATA_W-1:0] RST_POLYNOMIAL   = 64'h0000_0000_04C1_1DB7;
  localparam logic [CFG_DATA_W-1:0] RST_INITIAL      = 64'h0000_0000_FFFF_FFFF;
  localparam logic [CFG_DATA_W-1:0] RST_FINAL_XOR    = 64'h0000_0000_FFFF_FFFF;
  localparam logic                  RST_REFLECT_IN   = 1'b1;
  localparam logic                  RST_REFLECT_OUT  = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WIDTH_SELECT   = 3'd0,
    REG_POLYNOMIAL     = 3'd1,
    REG_INITIAL_VALUE  = 3'd2,
    REG_FINAL_XOR      = 3'd3,
    REG_REFLECT_INPUT  = 3'd4,
    REG_REFLECT_OUTPUT = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]            width_select;
    logic [CFG_DATA_W-1:0] polynomial;
    logic [CFG_DATA_W-1:0] initial_value;
    logic [CFG_DATA_W-1:0] final_xor;
    logic                  reflect_input;
    logic                  reflect_output;
  } cfg_t;

endpackage

// File: src/pce_in_if.sv
// request channel carrying message bytes into the crc engine
// no dependencies
interface pce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: src/pce_out_if.sv
// result channel carrying finished crc values
// depends on pce_pkg
interface pce_out_if;
  logic                       valid;
  logic                       ready;
  logic [pce_pkg::CRC_W-1:0]  crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink   (input valid, input crc_value, output ready);
endinterface

// File: src/pce_cfg_regs.sv
// configuration register file of the crc engine, write only
// depends on pce_pkg
module pce_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [pce_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pce_pkg::CFG_DATA_W-1:0]     cfg_data,
  output pce_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width_select   <= pce_pkg::RST_WIDTH_SELECT;
      cfg.polynomial     <= pce_pkg::RST_POLYNOMIAL;
      cfg.initial_value  <= pce_pkg::RST_INITIAL;
      cfg.final_xor      <= pce_pkg::RST_FINAL_XOR;
      cfg.reflect_input  <= pce_pkg::RST_REFLECT_IN;
      cfg.reflect_output <= pce_pkg::RST_REFLECT_OUT;
    end else if (cfg_write) begin
      case (cfg_index)
        pce_pkg::REG_WIDTH_SELECT:   cfg.width_select   <= cfg_data[1:0];
        pce_pkg::REG_POLYNOMIAL:     cfg.polynomial     <= cfg_data;
        pce_pkg::REG_INITIAL_VALUE:  cfg.initial_value  <= cfg_data;
        pce_pkg::REG_FINAL_XOR:      cfg.final_xor      <= cfg_data;
        pce_pkg::REG_REFLECT_INPUT:  cfg.reflect_input  <= cfg_data[0];
        pce_pkg::REG_REFLECT_OUTPUT: cfg.reflect_output <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

// File: src/pce_byte_update.sv
// one-byte crc update: input reflection, eight shift-xor steps, output reflection and final xor
// depends on pce_pkg
module pce_byte_update #(
  parameter int REG_W = pce_pkg::MAX_CRC_BITS
) (
  input  pce_pkg::cfg_t              cfg,
  input  logic                       start,
  input  logic [REG_W-1:0]           crc_cur,
  input  logic [7:0]                 data_byte,
  output logic [REG_W-1:0]           crc_next,
  output logic [pce_pkg::CRC_W-1:0]  crc_result
);

  localparam int MAX_SEL = $clog2(REG_W / 8);
  localparam int SHW     = $clog2(REG_W) + 1;

  logic [1:0]       sel;
  logic [SHW-1:0]   width_bits;
  logic [SHW-1:0]   shamt;
  logic [REG_W-1:0] poly_l;
  logic [REG_W-1:0] crc_l;
  logic [REG_W-1:0] crc_rev;
  logic [REG_W-1:0] fin;
  logic [REG_W-1:0] res;
  logic [7:0]       b;

  // register is worked left-justified so the feedback bit is always the msb
  always_comb begin
    sel        = (cfg.width_select > 2'(MAX_SEL)) ? 2'(MAX_SEL) : cfg.width_select;
    width_bits = SHW'(8) << sel;
    shamt      = SHW'(REG_W) - width_bits;
    poly_l     = cfg.polynomial[REG_W-1:0] << shamt;
    crc_l      = (start ? cfg.initial_value[REG_W-1:0] : crc_cur) << shamt;
    for (int i = 0; i < 8; i++) begin
      b[i] = cfg.reflect_input ? data_byte[7-i] : data_byte[i];
    end
    crc_l = crc_l ^ (REG_W'(b) << (REG_W - 8));
    for (int k = 0; k < 8; k++) begin
      crc_l = crc_l[REG_W-1] ? ((crc_l << 1) ^ poly_l) : (crc_l << 1);
    end
    crc_next = crc_l >> shamt;
    for (int i = 0; i < REG_W; i++) begin
      crc_rev[i] = crc_l[REG_W-1-i];
    end
    fin        = (cfg.final_xor[REG_W-1:0] << shamt) >> shamt;
    res        = (cfg.reflect_output ? crc_rev : crc_next) ^ fin;
    crc_result = pce_pkg::CRC_W'(res);
  end

endmodule

// File: src/parametric_crc_engine.sv
// top level of the parametric crc engine
// depends on pce_pkg, pce_in_if, pce_out_if, pce_cfg_regs, pce_byte_update
//
// usage:
//   msg carries one message byte per request with a last_byte flag; crc returns
//   one request holding the finished crc (low width bits, upper bits zero) for
//   every byte marked last. bytes not marked last produce nothing.
//   the config port writes width, polynomial, initial value, final xor and the
//   two reflection flags; write only between messages or while no byte is in
//   flight. a new message starts from initial_value after every last byte.
// timing:
//   a byte is registered in the input stage on acceptance and folded into the
//   running register as it leaves that stage, eight shift-xor steps in one
//   combinational pass; a crc is registered when its last byte leaves it.
//   one byte is accepted per cycle while no last byte waits in the input stage.
// reset:
//   rst clears both stages, marks the next byte as a message start and loads
//   the crc-32 defaults into the config registers.
// stall:
//   while crc is held off a finished result waits in its output register;
//   bytes not marked last keep flowing, and the next last byte waits in the
//   input stage, which then stops accepting.
module parametric_crc_engine #(
  parameter int MAX_CRC_BITS = pce_pkg::MAX_CRC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [pce_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pce_pkg::CFG_DATA_W-1:0]   cfg_data,
  pce_in_if.sink                           msg,
  pce_out_if.source                        crc
);

  localparam int MAX_SEL = (MAX_CRC_BITS >= 64) ? 3 :
                           (MAX_CRC_BITS >= 32) ? 2 :
                           (MAX_CRC_BITS >= 16) ? 1 : 0;
  localparam int REG_W   = 8 << MAX_SEL;

  pce_pkg::cfg_t cfg;

  logic                      stage_valid;
  logic [7:0]                stage_data;
  logic                      stage_last;
  logic [REG_W-1:0]          crc_reg;
  logic                      msg_start;
  logic                      result_valid;
  logic [pce_pkg::CRC_W-1:0] result_crc;

  logic                      out_free;
  logic                      advance;
  logic                      take;
  logic [REG_W-1:0]          crc_next;
  logic [pce_pkg::CRC_W-1:0] crc_result;

  pce_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pce_byte_update #(.REG_W(REG_W)) u_update (
    .cfg        (cfg),
    .start      (msg_start),
    .crc_cur    (crc_reg),
    .data_byte  (stage_data),
    .crc_next   (crc_next),
    .crc_result (crc_result)
  );

  assign out_free  = !result_valid || crc.ready;
  assign advance   = stage_valid && (!stage_last || out_free);
  assign msg.ready = !stage_valid || advance;
  assign take      = msg.valid && msg.ready;

  assign crc.valid     = result_valid;
  assign crc.crc_value = result_crc;

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage_data <= msg.data_byte;
      stage_last <= msg.last_byte;
    end
  end

  // running remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg   <= '0;
      msg_start <= 1'b1;
    end else if (advance) begin
      crc_reg   <= crc_next;
      msg_start <= stage_last;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && stage_last) begin
      result_valid <= 1'b1;
    end else if (crc.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_last) begin
      result_crc <= crc_result;
    end
  end

endmodule
